FILE: hw/rtl/ipd_pkg.sv
// Shared constants and types for the IPD frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned PlenW    = 6;

  localparam logic [CfgIdxW-1:0] RegStartMode     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegPayloadLength = CfgIdxW'(1);

  localparam logic [PlenW-1:0] PayloadLenReset = PlenW'(13);

  localparam logic [7:0] CharI     = 8'h49;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharColon = 8'h3A;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic store_enable;
    logic frame_done;
    logic field_abort;
  } res_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ipd_if.sv
// Handshake interfaces for the received bytes, the results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface ipd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipd_res_if #(
  parameter int unsigned IdxW = 6
);
  logic            valid;
  logic            ready;
  logic            store_enable;
  logic [IdxW-1:0] store_index;
  logic [7:0]      store_byte;
  logic            frame_done;
  logic            field_abort;

  modport source (output valid, output store_enable, output store_index, output store_byte,
                  output frame_done, output field_abort, input ready);
  modport sink   (input valid, input store_enable, input store_index, input store_byte,
                  input frame_done, input field_abort, output ready);
endinterface

interface ipd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ipd_pkg::CfgIdxW-1:0]  index;
  logic [ipd_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ipd_parse_ctrl.sv
// Parser state, configuration registers and the per-byte decision logic.
`timescale 1ns / 1ps
`default_nettype none

module ipd_parse_ctrl #(
  parameter int unsigned BUFFER_SIZE = 50
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [7:0]                  rx_byte_i,
  input  wire ipd_pkg::cfg_write_t         cfg_i,
  output ipd_pkg::res_flags_t              flags_o,
  output logic [$clog2(BUFFER_SIZE)-1:0]   store_index_o,
  output logic [7:0]                       store_byte_o
);

  localparam int unsigned PosW = $clog2(BUFFER_SIZE);
  localparam int unsigned CmpW = ((PosW > ipd_pkg::PlenW) ? PosW : ipd_pkg::PlenW) + 1;

  localparam logic [2:0] PhRaw     = 3'd0;
  localparam logic [2:0] PhI       = 3'd1;
  localparam logic [2:0] PhP       = 3'd2;
  localparam logic [2:0] PhD       = 3'd3;
  localparam logic [2:0] PhComma   = 3'd4;
  localparam logic [2:0] PhSocket  = 3'd5;
  localparam logic [2:0] PhLength  = 3'd6;
  localparam logic [2:0] PhPayload = 3'd7;

  logic [2:0]                phase_q, phase_d;
  logic [PosW-1:0]           pos_q, pos_d;
  logic                      halted_q, halted_d;
  logic [ipd_pkg::PlenW-1:0] plen_q, plen_d;

  logic            pos_last;
  logic [PosW-1:0] pos_inc;
  logic [CmpW-1:0] plen_eff;
  logic [CmpW-1:0] pos_next_ext;

  assign pos_last     = (pos_q == PosW'(BUFFER_SIZE - 1));
  assign pos_inc      = pos_q + PosW'(1);
  assign pos_next_ext = CmpW'(pos_q) + CmpW'(1);

  // Payload length of zero counts as one; anything above the buffer saturates.
  always_comb begin
    if (plen_q == '0) begin
      plen_eff = CmpW'(1);
    end else if (CmpW'(plen_q) > CmpW'(BUFFER_SIZE)) begin
      plen_eff = CmpW'(BUFFER_SIZE);
    end else begin
      plen_eff = CmpW'(plen_q);
    end
  end

  always_comb begin
    phase_d       = phase_q;
    pos_d         = pos_q;
    halted_d      = halted_q;
    plen_d        = plen_q;
    flags_o       = '0;
    store_index_o = '0;
    store_byte_o  = '0;

    if (step_i && !halted_q) begin
      unique case (phase_q)
        PhRaw: begin
          flags_o.store_enable = 1'b1;
          store_index_o        = pos_q;
          store_byte_o         = rx_byte_i;
          pos_d                = pos_last ? '0 : pos_inc;
        end
        PhI: begin
          if (rx_byte_i == ipd_pkg::CharI) begin
            phase_d = PhP;
          end else begin
            pos_d = '0;
          end
        end
        PhP: begin
          if (rx_byte_i == ipd_pkg::CharP) begin
            phase_d = PhD;
          end else begin
            pos_d   = '0;
            phase_d = PhI;
          end
        end
        PhD: begin
          if (rx_byte_i == ipd_pkg::CharD) begin
            phase_d = PhComma;
          end else begin
            pos_d   = '0;
            phase_d = PhI;
          end
        end
        PhComma: begin
          pos_d   = '0;
          phase_d = (rx_byte_i == ipd_pkg::CharComma) ? PhSocket : PhI;
        end
        PhSocket: begin
          if (rx_byte_i == ipd_pkg::CharComma) begin
            phase_d = PhLength;
            pos_d   = '0;
          end else if (pos_last) begin
            pos_d               = '0;
            phase_d             = PhI;
            flags_o.field_abort = 1'b1;
          end else begin
            pos_d = pos_inc;
          end
        end
        PhLength: begin
          if (rx_byte_i == ipd_pkg::CharColon) begin
            phase_d = PhPayload;
            pos_d   = '0;
          end else begin
            flags_o.store_enable = 1'b1;
            store_index_o        = pos_q;
            store_byte_o         = rx_byte_i;
            if (pos_last) begin
              pos_d               = '0;
              phase_d             = PhI;
              flags_o.field_abort = 1'b1;
            end else begin
              pos_d = pos_inc;
            end
          end
        end
        PhPayload: begin
          flags_o.store_enable = 1'b1;
          store_index_o        = pos_q;
          store_byte_o         = rx_byte_i;
          if (pos_next_ext >= plen_eff) begin
            pos_d              = '0;
            phase_d            = PhRaw;
            halted_d           = 1'b1;
            flags_o.frame_done = 1'b1;
          end else begin
            pos_d = pos_inc;
          end
        end
        default: begin
          phase_d = PhRaw;
        end
      endcase
    end

    // Writing start_mode restarts the parser from the new mode.
    if (cfg_i.valid) begin
      if (cfg_i.index == ipd_pkg::RegStartMode) begin
        phase_d      = cfg_i.data[0] ? PhI : PhRaw;
        pos_d        = '0;
        halted_d     = 1'b0;
      end else if (cfg_i.index == ipd_pkg::RegPayloadLength) begin
        plen_d = cfg_i.data[ipd_pkg::PlenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhRaw;
      pos_q        <= '0;
      halted_q     <= 1'b0;
      plen_q       <= ipd_pkg::PayloadLenReset;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      halted_q     <= halted_d;
      plen_q       <= plen_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ipd_frame_receiver.sv
// Top level of the IPD frame receiver: input register, parser and result register.
//
//  Channel  Direction  Payload                                           Transaction when
//  rx_i     in         rx_byte                                           valid && ready
//  res_o    out        store_enable, store_index, store_byte,            valid && ready
//                      frame_done, field_abort
//  cfg_i    in         index (0 start_mode, 1 payload_length), data      valid (ready held high)
//
// One byte per cycle is accepted while res_o is not stalled; each result passes through the
// input register, then the result register. Reset leaves raw capture mode at position
// zero with a payload length of 13. A stalled result holds the input register,
// which in turn drops rx_i.ready; a byte is taken whenever the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module ipd_frame_receiver #(
  parameter int unsigned BUFFER_SIZE = 50
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  ipd_rx_if.sink    rx_i,
  ipd_res_if.source res_o,
  ipd_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = $clog2(BUFFER_SIZE);

  logic                s1_valid_q;
  logic [7:0]          s1_byte_q;
  logic                s1_advance;
  logic                out_valid_q;
  ipd_pkg::res_flags_t out_flags_q;
  logic [IdxW-1:0]     out_index_q;
  logic [7:0]          out_byte_q;

  ipd_pkg::cfg_write_t cfg_wr;
  ipd_pkg::res_flags_t step_flags;
  logic [IdxW-1:0]     step_index;
  logic [7:0]          step_byte;

  assign s1_advance = s1_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !s1_valid_q || s1_advance;
  assign cfg_i.ready = 1'b1;

  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  ipd_parse_ctrl #(
    .BUFFER_SIZE(BUFFER_SIZE)
  ) u_parse_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_advance),
    .rx_byte_i    (s1_byte_q),
    .cfg_i        (cfg_wr),
    .flags_o      (step_flags),
    .store_index_o(step_index),
    .store_byte_o (step_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        s1_valid_q <= rx_i.valid;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
    end
    if (s1_advance) begin
      out_flags_q <= step_flags;
      out_index_q <= step_index;
      out_byte_q  <= step_byte;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.store_enable = out_flags_q.store_enable;
  assign res_o.store_index  = out_index_q;
  assign res_o.store_byte   = out_byte_q;
  assign res_o.frame_done   = out_flags_q.frame_done;
  assign res_o.field_abort  = out_flags_q.field_abort;

endmodule

`default_nettype wire

FILE: sim/ipd_frame_receiver_tb.sv
// Self-checking testbench for the IPD frame receiver: byte stimulus, prediction and result checks.
`timescale 1ns / 1ps

module ipd_frame_receiver_tb;

  localparam int unsigned BufSize = 50;
  localparam logic [ipd_pkg::CfgIdxW-1:0] RegLast = '1;
  localparam logic [7:0] CharZero = 8'h30;

  typedef enum logic [2:0] {
    PhRaw, PhSeekI, PhSeekP, PhSeekD, PhSeekComma, PhSocket, PhLength, PhPayload
  } parse_phase_e;

  typedef struct packed {
    logic       store_enable;
    logic [5:0] store_index;
    logic [7:0] store_byte;
    logic       frame_done;
    logic       field_abort;
  } store_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ipd_rx_if             rx ();
  ipd_res_if #(.IdxW(6)) res ();
  ipd_cfg_if            cfg ();

  ipd_frame_receiver #(
    .BUFFER_SIZE(BufSize)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx),
    .res_o (res),
    .cfg_i (cfg)
  );

  // Parser state as the testbench expects it to be.
  logic         mode_bit   = 1'b0;
  logic [5:0]   plen_reg   = ipd_pkg::PayloadLenReset;
  parse_phase_e hunt_phase = PhRaw;
  int unsigned  buf_pos    = 0;
  logic         is_halted  = 1'b0;

  logic [7:0]  pending [$];
  store_res_t  store_want_q [$];
  logic        byte_taken = 1'b0;
  int unsigned rx_gap_pct = 10;
  int unsigned res_stall_pct = 10;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned bytes_queued = 0;

  int n_errors = 0;
  int n_results = 0;
  int n_stored = 0;
  int n_frames = 0;
  int n_aborts = 0;
  int n_writes = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic store_res_t parse_byte(input logic [7:0] b);
    store_res_t  r;
    int unsigned lim;
    r = '0;
    lim = (plen_reg == 0) ? 1 : ((plen_reg > BufSize) ? BufSize : plen_reg);
    if (!is_halted) begin
      case (hunt_phase)
        PhRaw: begin
          r.store_enable = 1'b1;
          r.store_index  = 6'(buf_pos);
          r.store_byte   = b;
          buf_pos = (buf_pos + 1 >= BufSize) ? 0 : buf_pos + 1;
        end
        PhSeekI: begin
          if (b == ipd_pkg::CharI) hunt_phase = PhSeekP;
          else buf_pos = 0;
        end
        PhSeekP: begin
          if (b == ipd_pkg::CharP) hunt_phase = PhSeekD;
          else begin
            buf_pos = 0;
            hunt_phase = PhSeekI;
          end
        end
        PhSeekD: begin
          if (b == ipd_pkg::CharD) hunt_phase = PhSeekComma;
          else begin
            buf_pos = 0;
            hunt_phase = PhSeekI;
          end
        end
        PhSeekComma: begin
          buf_pos = 0;
          hunt_phase = (b == ipd_pkg::CharComma) ? PhSocket : PhSeekI;
        end
        PhSocket: begin
          if (b == ipd_pkg::CharComma) begin
            hunt_phase = PhLength;
            buf_pos = 0;
          end else begin
            // The socket field is only counted, never stored.
            buf_pos++;
            if (buf_pos >= BufSize) begin
              buf_pos = 0;
              hunt_phase = PhSeekI;
              r.field_abort = 1'b1;
            end
          end
        end
        PhLength: begin
          if (b == ipd_pkg::CharColon) begin
            hunt_phase = PhPayload;
            buf_pos = 0;
          end else begin
            r.store_enable = 1'b1;
            r.store_index  = 6'(buf_pos);
            r.store_byte   = b;
            buf_pos++;
            if (buf_pos >= BufSize) begin
              buf_pos = 0;
              hunt_phase = PhSeekI;
              r.field_abort = 1'b1;
            end
          end
        end
        default: begin
          r.store_enable = 1'b1;
          r.store_index  = 6'(buf_pos);
          r.store_byte   = b;
          buf_pos++;
          if (buf_pos >= lim) begin
            buf_pos = 0;
            hunt_phase = PhRaw;
            is_halted = 1'b1;
            r.frame_done = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] rand_except(input logic [7:0] avoid);
    logic [7:0] v;
    v = 8'($urandom);
    if (v == avoid) v = ~avoid;
    return v;
  endfunction

  // Random bytes weighted toward the characters the parser reacts to.
  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: v = ipd_pkg::CharI;
      1: v = ipd_pkg::CharP;
      2: v = ipd_pkg::CharD;
      3: v = ipd_pkg::CharComma;
      4: v = ipd_pkg::CharColon;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_pct();
    int unsigned p;
    case ($urandom_range(0, 2))
      0: p = 0;
      1: p = 10;
      default: p = 35;
    endcase
    return p;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_header();
    push_byte(ipd_pkg::CharI);
    push_byte(ipd_pkg::CharP);
    push_byte(ipd_pkg::CharD);
    push_byte(ipd_pkg::CharComma);
  endtask

  task automatic cmp_field(input string what, input logic [7:0] want_v, input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      n_errors++;
    end
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || rx.valid === 1'b1 || store_want_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ipd_pkg::CfgIdxW-1:0] idx,
                           input logic [ipd_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Byte driver: holds each byte until its transaction, with random gaps in between.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (byte_taken) void'(pending.pop_front());
      if (rx.valid && !byte_taken) begin
        // Stalled: keep the current byte on the channel.
      end else if (gap_left != 0) begin
        gap_left--;
        rx.valid <= 1'b0;
      end else if (pending.size() != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
        gap_left = $urandom_range(0, 3);
        rx.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        rx.valid   <= 1'b1;
        rx.rx_byte <= pending[0];
      end else begin
        rx.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < res_stall_pct) begin
      stall_left = $urandom_range(0, 3);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // Monitor: predicts on every accepted byte and checks every result transaction.
  always @(posedge clk_i) begin : monitor
    store_res_t got;
    store_res_t want;
    byte_taken = rst_ni && rx.valid && rx.ready;
    if (rst_ni) begin
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        got = {res.store_enable, res.store_index, res.store_byte, res.frame_done,
               res.field_abort};
        n_results++;
        if (store_want_q.size() == 0) begin
          $display("%0t: result with no byte outstanding, expected none, actual %0h",
                   $time, got);
          n_errors++;
        end else begin
          want = store_want_q.pop_front();
          cmp_field("store_enable", 8'(want.store_enable), 8'(got.store_enable));
          cmp_field("store_index", 8'(want.store_index), 8'(got.store_index));
          cmp_field("store_byte", want.store_byte, got.store_byte);
          cmp_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
          cmp_field("field_abort", 8'(want.field_abort), 8'(got.field_abort));
          if (want.store_enable) n_stored++;
          if (want.frame_done) n_frames++;
          if (want.field_abort) n_aborts++;
        end
      end
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        n_writes++;
        case (cfg.index)
          ipd_pkg::RegStartMode: begin
            mode_bit   = cfg.data[0];
            hunt_phase = cfg.data[0] ? PhSeekI : PhRaw;
            buf_pos    = 0;
            is_halted  = 1'b0;
          end
          ipd_pkg::RegPayloadLength: plen_reg = cfg.data[5:0];
          default: ;
        endcase
      end
      if (byte_taken) store_want_q.push_back(parse_byte(rx.rx_byte));
    end
  end

  initial begin : stimulus
    logic [7:0]                  d;
    logic [7:0]                  next_ch;
    logic [ipd_pkg::CfgIdxW-1:0] ri;
    logic [7:0]                  opening [$];
    int unsigned                 gen_plen;
    int unsigned                 pick;
    int unsigned                 k;

    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    res.ready  = 1'b0;
    cfg.valid  = 1'b0;
    cfg.index  = '0;
    cfg.data   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Raw capture straight out of reset, then the frame special cases with a one-byte payload.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    push_byte(8'hA5);
    wait_idle();
    write_reg(ipd_pkg::RegPayloadLength, 8'hC0);
    gen_plen = 1;
    write_reg(ipd_pkg::RegStartMode, 8'h01);
    opening = '{ipd_pkg::CharI, ipd_pkg::CharI,
                ipd_pkg::CharI, ipd_pkg::CharP, ipd_pkg::CharI,
                ipd_pkg::CharI, ipd_pkg::CharP, ipd_pkg::CharD, ipd_pkg::CharD,
                ipd_pkg::CharI, ipd_pkg::CharP, ipd_pkg::CharD, ipd_pkg::CharComma,
                ipd_pkg::CharComma, CharZero + 8'd7, ipd_pkg::CharColon, 8'hFF,
                ipd_pkg::CharI};
    foreach (opening[i]) push_byte(opening[i]);
    wait_idle();

    while (bytes_queued < 1900) begin
      if (bytes_queued > 1650) begin
        rx_gap_pct = 0;
        res_stall_pct = 0;
      end else begin
        rx_gap_pct = pick_pct();
        res_stall_pct = pick_pct();
      end
      if ($urandom_range(0, 2) == 0) begin
        d = 8'($urandom);
        case ($urandom_range(0, 5))
          0: d[5:0] = 6'd0;
          1: d[5:0] = 6'(BufSize);
          2: d[5:0] = 6'($urandom_range(BufSize + 1, 63));
          3: d[5:0] = 6'd1;
          default: d[5:0] = 6'($urandom_range(2, 12));
        endcase
        write_reg(ipd_pkg::RegPayloadLength, d);
        gen_plen = (d[5:0] == 0) ? 1 : ((d[5:0] > BufSize) ? BufSize : d[5:0]);
      end
      if ($urandom_range(0, 9) == 0) begin
        ri = ipd_pkg::CfgIdxW'($urandom_range(int'(ipd_pkg::RegPayloadLength) + 1,
                                              int'(RegLast)));
        write_reg(ri, 8'($urandom));
      end
      d = 8'($urandom);
      d[0] = ($urandom_range(0, 4) != 0);
      write_reg(ipd_pkg::RegStartMode, d);

      if (!d[0]) begin
        repeat ($urandom_range(30, 110)) push_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 3)) begin
          pick = $urandom_range(0, 11);
          if (pick < 5) begin
            repeat ($urandom_range(1, 6)) push_byte(noise_byte());
          end else if (pick < 10) begin
            // A header broken off after one, two or three characters.
            k = $urandom_range(1, 3);
            push_byte(ipd_pkg::CharI);
            if (k >= 2) push_byte(ipd_pkg::CharP);
            if (k >= 3) push_byte(ipd_pkg::CharD);
            next_ch = (k == 1) ? ipd_pkg::CharP :
                      ((k == 2) ? ipd_pkg::CharD : ipd_pkg::CharComma);
            push_byte($urandom_range(0, 1) ? ipd_pkg::CharI : rand_except(next_ch));
          end else begin
            push_header();
            if (pick == 10) begin
              repeat (BufSize) push_byte(rand_except(ipd_pkg::CharComma));
            end else begin
              repeat ($urandom_range(0, 2)) push_byte(CharZero + 8'($urandom_range(0, 9)));
              push_byte(ipd_pkg::CharComma);
              repeat (BufSize) push_byte(rand_except(ipd_pkg::CharColon));
            end
          end
        end
        if ($urandom_range(0, 9) != 0) begin
          push_header();
          repeat ($urandom_range(0, 3)) push_byte(CharZero + 8'($urandom_range(0, 9)));
          push_byte(ipd_pkg::CharComma);
          repeat ($urandom_range(0, 3)) push_byte(CharZero + 8'($urandom_range(0, 9)));
          push_byte(ipd_pkg::CharColon);
          repeat (gen_plen) push_byte(8'($urandom));
          // Bytes after the frame are dropped while halted.
          repeat ($urandom_range(0, 3)) pending.push_back(noise_byte());
        end
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (store_want_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, store_want_q.size(), store_want_q.size());
      n_errors++;
    end
    $display("Checked %0d results: %0d bytes stored, %0d frames completed, %0d field aborts.",
             n_results, n_stored, n_frames, n_aborts);
    $display("Register writes: %0d, across raw capture and frame hunting phases.", n_writes);
    if (n_errors == 0) begin
      $display("PASS ipd_frame_receiver");
    end else begin
      $display("FAIL ipd_frame_receiver");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL ipd_frame_receiver");
    $finish;
  end

endmodule
